// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by centered_moving_average_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CMA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CMA_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CMA_ASSERT(lbl, clk, rst, prop, msg)
`define CMA_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ===== rtl/core/cma_pkg.sv =====
package cma_pkg;

  localparam int LEN_W            = 4;
  localparam int LEN_MAX          = 15;
  localparam logic [LEN_W-1:0] LEN_RESET = 4'd5;

  localparam int HALF_MAX_DEF     = 7;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH_DEF  = 16;

  // request from the sequencer to the divider
  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] divisor;
  } cma_div_req_t;

endpackage

// ===== rtl/core/cma_divider.sv =====
module cma_divider import cma_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  cma_div_req_t                        req,
  input  logic signed [SAMPLE_WIDTH+LEN_W-1:0] dividend,
  output logic                                done,
  output logic        [SAMPLE_WIDTH-1:0]      quotient
);

  localparam int SUM_W  = SAMPLE_WIDTH + LEN_W;
  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [SUM_W-1:0] MAG_MAX = {{(SUM_W-SAMPLE_WIDTH+1){1'b0}},
                                          {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] POS_SAT = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] NEG_SAT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIN} dv_state_t;

  dv_state_t          state;
  logic [STEP_W-1:0]  step;
  logic [SUM_W-1:0]   quo;
  logic [LEN_W-1:0]   rem;
  logic [LEN_W-1:0]   dvsr;
  logic               neg;

  logic [LEN_W:0]        rem_shift;
  logic [LEN_W:0]        diff;
  logic                  q_bit;
  logic [LEN_W-1:0]      rem_next;
  logic [SAMPLE_WIDTH-1:0] sat;

  // one restoring step a cycle on the magnitude
  always_comb begin
    rem_shift = {rem, quo[SUM_W-1]};
    diff      = rem_shift - {1'b0, dvsr};
    q_bit     = ~diff[LEN_W];
    rem_next  = q_bit ? diff[LEN_W-1:0] : rem_shift[LEN_W-1:0];
  end

  // sign restore with saturation, truncation toward zero comes from the magnitude
  always_comb begin
    if (neg) begin
      sat = (quo > MAG_MAX) ? NEG_SAT : (~quo[SAMPLE_WIDTH-1:0] + 1'b1);
    end else begin
      sat = (quo > MAG_MAX) ? POS_SAT : quo[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        DV_IDLE: begin
          done <= 1'b0;
          if (req.start) begin
            neg   <= dividend[SUM_W-1];
            quo   <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem   <= '0;
            dvsr  <= req.divisor;
            step  <= '0;
            state <= DV_RUN;
          end
        end
        DV_RUN: begin
          rem <= rem_next;
          quo <= {quo[SUM_W-2:0], q_bit};
          if (step == STEP_W'(SUM_W - 1)) begin
            state <= DV_FIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        DV_FIN: begin
          quotient <= sat;
          done     <= 1'b1;
          state    <= DV_IDLE;
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/centered_moving_average_core.sv =====
// centered moving average over a finite signal
// input beats on s_axis: tdata carries one signed q16.16 sample, tlast marks
// the final sample of the signal. result beats on m_axis: tdata carries the
// smoothed sample, tuser is high for a window average and low for an edge
// pass-through, tlast marks the final result of the signal.
// half-width k is window_length/2 (capped at HALF_MAX and LEN_MAX/2), latched with the first
// sample of each signal; cfg writes take effect with the next signal.
// result m leaves when sample m+k arrives, the last sample flushes the rest.
// one sample is worked on at a time; s_axis_tready is low while busy.
// an averaged result is registered once its 2k+1 taps have been summed
// through the accumulator and the bit-serial divider has run its
// SAMPLE_WIDTH+4 steps. a pass-through result is registered from the delay
// line after the plan state, each further flushed result after the plan
// state that follows the beat before it. ready returns after the plan state
// that follows the last result beat of a sample finds no work left.
// when m_axis_tready is low the result is held in the output register and
// nothing else moves.
// reset clears the delay line and the sample counter and sets window_length to 5.
`include "assert_macros.svh"

module centered_moving_average_core import cma_pkg::*; #(
  parameter int HALF_MAX     = HALF_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [LEN_W-1:0]                     cfg_wr_data,   // window_length
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [8*((SAMPLE_WIDTH+7)/8)-1:0]    s_axis_tdata,  // sample_value
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [8*((SAMPLE_WIDTH+7)/8)-1:0]    m_axis_tdata,  // smoothed_value
  output logic                                 m_axis_tuser,  // was_averaged
  output logic                                 m_axis_tlast
);

  localparam int TDATA_W    = 8 * ((SAMPLE_WIDTH + 7) / 8);
  localparam int K_LIM      = (HALF_MAX < LEN_MAX / 2) ? HALF_MAX : LEN_MAX / 2;
  localparam int LINE_DEPTH = 2 * K_LIM + 1;
  localparam int IDX_W      = $clog2(LINE_DEPTH);
  localparam int KW         = $clog2(K_LIM + 1);
  localparam int SUM_W      = SAMPLE_WIDTH + LEN_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {S_IDLE, S_PLAN, S_SUM, S_DIV, S_PASS, S_OUT} state_t;

  state_t                          state;
  logic        [LEN_W-1:0]         window_length;
  logic        [LEN_W-1:0]         active_length;
  logic        [LEN_W-1:0]         len_reg;
  logic        [KW-1:0]            k_reg;
  logic        [COUNT_WIDTH-1:0]   sample_count;
  logic signed [SAMPLE_WIDTH-1:0]  line [LINE_DEPTH];
  logic        [IDX_W-1:0]         rd_idx;
  logic signed [SUM_W-1:0]         acc;
  logic                            main_todo;
  logic                            main_avg;
  logic                            flush_todo;
  logic        [KW-1:0]            flush_idx;
  logic                            item_last;
  logic        [SAMPLE_WIDTH-1:0]  out_data;
  logic                            out_avg;
  logic                            out_last;
  logic                            div_start;

  logic                            in_beat;
  logic signed [SAMPLE_WIDTH-1:0]  in_sample;
  logic        [LEN_W-1:0]         eff_raw;
  logic        [LEN_W-1:0]         len_eff;
  logic        [LEN_W-1:0]         half;
  logic        [KW-1:0]            k_new;
  logic                            n_ge_k;
  logic                            n_ge_2k;
  logic        [KW-1:0]            top_new;
  logic signed [SAMPLE_WIDTH-1:0]  tap;
  logic        [IDX_W-1:0]         sum_end;

  cma_div_req_t                    div_req;
  logic                            div_done;
  logic        [SAMPLE_WIDTH-1:0]  div_quot;

  assign s_axis_tready = (state == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign in_sample     = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign tap           = line[rd_idx];
  assign sum_end       = IDX_W'({k_reg, 1'b0});

  assign m_axis_tdata  = TDATA_W'(out_data);
  assign m_axis_tuser  = out_avg;
  assign m_axis_tlast  = out_last;

  // plan for the sample being taken
  always_comb begin
    eff_raw = (sample_count == '0) ? window_length : active_length;
    len_eff = (eff_raw == '0) ? LEN_W'(1) : eff_raw;
    half    = len_eff >> 1;
    k_new   = (half > LEN_W'(K_LIM)) ? KW'(K_LIM) : KW'(half);
    n_ge_k  = sample_count >= COUNT_WIDTH'(k_new);
    n_ge_2k = sample_count >= COUNT_WIDTH'({k_new, 1'b0});
    top_new = n_ge_k ? KW'(k_new - KW'(1)) : KW'(sample_count);
  end

  assign div_req.start   = div_start;
  assign div_req.divisor = len_reg;

  cma_divider #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (acc),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= LEN_RESET;
      active_length <= LEN_RESET;
      sample_count  <= '0;
      main_todo     <= 1'b0;
      flush_todo    <= 1'b0;
      div_start     <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        line[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        window_length <= cfg_wr_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            for (int i = LINE_DEPTH - 1; i > 0; i--) begin
              line[i] <= line[i-1];
            end
            line[0]       <= in_sample;
            active_length <= eff_raw;
            len_reg       <= len_eff;
            k_reg         <= k_new;
            main_todo     <= n_ge_k;
            main_avg      <= n_ge_2k;
            flush_todo    <= s_axis_tlast && (k_new != '0);
            flush_idx     <= top_new;
            item_last     <= s_axis_tlast;
            if (s_axis_tlast) begin
              sample_count <= '0;
            end else if (sample_count != COUNT_MAX) begin
              sample_count <= sample_count + 1'b1;
            end
            state <= S_PLAN;
          end
        end
        S_PLAN: begin
          priority if (main_todo && main_avg) begin
            rd_idx <= '0;
            acc    <= '0;
            state  <= S_SUM;
          end else if (main_todo) begin
            rd_idx <= IDX_W'(k_reg);
            state  <= S_PASS;
          end else if (flush_todo) begin
            rd_idx <= IDX_W'(flush_idx);
            state  <= S_PASS;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SUM: begin
          acc <= acc + SUM_W'(tap);
          if (rd_idx == sum_end) begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        S_DIV: begin
          div_start <= 1'b0;
          if (div_done) begin
            out_data      <= div_quot;
            out_avg       <= 1'b1;
            out_last      <= item_last && !flush_todo;
            main_todo     <= 1'b0;
            m_axis_tvalid <= 1'b1;
            state         <= S_OUT;
          end
        end
        S_PASS: begin
          out_data <= tap;
          out_avg  <= 1'b0;
          if (main_todo) begin
            main_todo <= 1'b0;
            out_last  <= item_last && !flush_todo;
          end else begin
            // flush walks from the oldest pending sample down to the newest
            out_last <= item_last && (flush_idx == '0);
            if (flush_idx == '0) begin
              flush_todo <= 1'b0;
            end else begin
              flush_idx <= flush_idx - 1'b1;
            end
          end
          m_axis_tvalid <= 1'b1;
          state         <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state         <= S_PLAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CMA_ASSERT(a_no_input_with_result, clk, rst, m_axis_tvalid |-> !s_axis_tready, "ready high")
  `CMA_ASSERT(a_busy_after_beat, clk, rst, in_beat |=> !s_axis_tready, "ready after beat")
  `CMA_ASSERT(a_last_cnt, clk, rst, m_axis_tvalid && m_axis_tlast |-> sample_count == '0, "count")
  `CMA_ASSERT(a_div_done_in_div, clk, rst, div_done |-> (state == S_DIV), "stray divide done")
  `CMA_ASSERT_NEVER(a_tap_in_window, clk, rst, state == S_SUM && rd_idx > sum_end, "tap past end")

endmodule
